### design/nlej_pkg.sv
// ----------------------------------------------------------------------------
// nlej_pkg
// Shared types, codes and helpers for the nested-loop equi-join engine.
// ----------------------------------------------------------------------------
package nlej_pkg;

    localparam int TABLE_ROWS = 64;
    localparam int FIELD_BITS = 32;
    localparam int WORD_BITS  = 32;
    localparam int IDX_W      = $clog2(TABLE_ROWS);
    localparam int CNT_W      = $clog2(TABLE_ROWS + 1);

    typedef logic [FIELD_BITS-1:0] col_t;
    typedef logic [WORD_BITS-1:0]  word_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    typedef struct packed {
        col_t id;
        col_t val1;
        col_t val2;
    } row_t;

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_PROBE = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_MATCH   = 3'd0,
        ST_NOMATCH = 3'd1,
        ST_STORED  = 3'd2,
        ST_FULL    = 3'd3,
        ST_CLEARED = 3'd4
    } status_t;

    localparam logic [1:0] KEY_ID   = 2'd0;
    localparam logic [1:0] KEY_VAL1 = 2'd1;
    localparam logic [1:0] KEY_VAL2 = 2'd2;

    localparam logic [1:0] KEY_ADDR = 2'd0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RESP,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        EMIT_RESP,
        EMIT_MID,
        EMIT_FINAL
    } emit_t;

    typedef struct packed {
        logic  capture;
        func_t op;
        logic  scan_step;
        logic  emit;
        emit_t emit_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic hit;
        logic pending;
        logic scan_done;
        logic out_free;
    } dp_status_t;

    function automatic col_t to_col(input word_t v);
        logic [63:0] w;
        w = 64'(v);
        return w[FIELD_BITS-1:0];
    endfunction

    function automatic word_t to_word(input col_t c);
        logic [63:0] w;
        w = 64'(c);
        return w[WORD_BITS-1:0];
    endfunction

endpackage

### design/nlej_ctrl.sv
// ----------------------------------------------------------------------------
// nlej_ctrl
// Sequencer: takes one word at a time, runs the table scan, issues emits.
// ----------------------------------------------------------------------------
module nlej_ctrl
    import nlej_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] func,
    input  dp_status_t stat,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = in_valid && (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (func_t'(func))
                        FUNC_LOAD, FUNC_CLEAR: state_next = S_RESP;
                        FUNC_PROBE:            state_next = S_SCAN;
                        default:               state_next = S_IDLE;
                    endcase
                end
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall      = 1'b1;
        cmd.capture   = 1'b0;
        cmd.op        = func_t'(func);
        cmd.scan_step = 1'b0;
        cmd.emit      = 1'b0;
        cmd.emit_sel  = EMIT_RESP;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = accept;
            end
            S_RESP:
            begin
                cmd.emit     = stat.out_free;
                cmd.emit_sel = EMIT_RESP;
            end
            S_SCAN:
            begin
                // a second hit pushes out the held one; wait if the output is busy
                if (!stat.scan_done)
                begin
                    cmd.scan_step = !(stat.hit && stat.pending && !stat.out_free);
                    cmd.emit      = stat.hit && stat.pending && stat.out_free;
                    cmd.emit_sel  = EMIT_MID;
                end
            end
            S_FINISH:
            begin
                cmd.emit     = stat.out_free;
                cmd.emit_sel = EMIT_FINAL;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

### design/nlej_dp.sv
// ----------------------------------------------------------------------------
// nlej_dp
// Datapath: row table, scan pipeline, key compare and output register.
// ----------------------------------------------------------------------------
module nlej_dp
    import nlej_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] key_column,
    input  word_t      row_id,
    input  word_t      row_val1,
    input  word_t      row_val2,
    input  dp_cmd_t    cmd,
    output dp_status_t stat,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] status,
    output word_t      out_id,
    output word_t      out_val1,
    output word_t      out_val2,
    output logic       last
);

    row_t    mem [TABLE_ROWS];
    row_t    left_reg;
    row_t    rd_row_reg;
    cnt_t    count_reg;
    cnt_t    addr_reg;
    logic    rd_valid_reg;
    logic    pending_reg;
    status_t resp_reg;

    logic    out_valid_reg;
    status_t out_status_reg;
    row_t    out_row_reg;
    logic    out_last_reg;

    row_t    in_row;
    logic    is_full;
    logic    wr_en;
    logic    issue;
    logic    key_eq;
    logic    out_free;

    assign in_row.id   = to_col(row_id);
    assign in_row.val1 = to_col(row_val1);
    assign in_row.val2 = to_col(row_val2);

    assign is_full  = (count_reg == CNT_W'(TABLE_ROWS));
    assign wr_en    = cmd.capture && (cmd.op == FUNC_LOAD) && !is_full;
    assign issue    = cmd.scan_step && (addr_reg != count_reg);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        case (key_column)
            KEY_ID:   key_eq = (rd_row_reg.id == left_reg.id);
            KEY_VAL1: key_eq = (rd_row_reg.val1 == left_reg.val1);
            KEY_VAL2: key_eq = (rd_row_reg.val2 == left_reg.val2);
            default:  key_eq = 1'b0;
        endcase
    end

    assign stat.hit       = rd_valid_reg && key_eq;
    assign stat.pending   = pending_reg;
    assign stat.scan_done = (addr_reg == count_reg) && !rd_valid_reg;
    assign stat.out_free  = out_free;

    // table storage, one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[IDX_W-1:0]] <= in_row;
        end
        if (issue)
        begin
            rd_row_reg <= mem[addr_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            addr_reg     <= '0;
            rd_valid_reg <= 1'b0;
            pending_reg  <= 1'b0;
        end
        else if (cmd.capture)
        begin
            addr_reg     <= '0;
            rd_valid_reg <= 1'b0;
            pending_reg  <= 1'b0;
            if (wr_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.op == FUNC_CLEAR)
            begin
                count_reg <= '0;
            end
        end
        else if (cmd.scan_step)
        begin
            rd_valid_reg <= issue;
            if (issue)
            begin
                addr_reg <= addr_reg + 1'b1;
            end
            if (stat.hit)
            begin
                pending_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            left_reg <= in_row;
            if (cmd.op == FUNC_CLEAR)
            begin
                resp_reg <= ST_CLEARED;
            end
            else if (is_full)
            begin
                resp_reg <= ST_FULL;
            end
            else
            begin
                resp_reg <= ST_STORED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            case (cmd.emit_sel)
                EMIT_MID:
                begin
                    out_status_reg <= ST_MATCH;
                    out_row_reg    <= left_reg;
                    out_last_reg   <= 1'b0;
                end
                EMIT_FINAL:
                begin
                    out_status_reg <= pending_reg ? ST_MATCH : ST_NOMATCH;
                    out_row_reg    <= pending_reg ? left_reg : '0;
                    out_last_reg   <= 1'b1;
                end
                default:
                begin
                    out_status_reg <= resp_reg;
                    out_row_reg    <= '0;
                    out_last_reg   <= 1'b1;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign out_id    = to_word(out_row_reg.id);
    assign out_val1  = to_word(out_row_reg.val1);
    assign out_val2  = to_word(out_row_reg.val2);
    assign last      = out_last_reg;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_ROWS))
        else $error("row count beyond table size");

    a_read_addr: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (addr_reg != '0) && (addr_reg <= count_reg))
        else $error("read data without a matching issued address");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("emit into an occupied output register");

    a_mid_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && (cmd.emit_sel == EMIT_MID)) |-> (pending_reg && stat.hit))
        else $error("non-final match emitted without a held match");
`endif

endmodule

### design/nested_loop_equi_join.sv
// ----------------------------------------------------------------------------
// nested_loop_equi_join
// Equi-join engine: stores right rows, probes left rows against the table.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  cfg     | in        | APB, pready tied 1   | key_column at byte 0
//  in      | in        | in_valid / in_stall  | func, row_id, row_val1, row_val2
//  out     | out       | out_valid / out_stall| status, out_id, out_val1, out_val2, last
//
// A probe reads every stored row through the single table read port, which
// delivers one stored row per cycle. One word is worked on at a time.
// Output stalls hold the scan only when a second match finds the output busy.
// Reset empties the table at once through the row count; no clearing pass.
module nested_loop_equi_join
    import nlej_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [31:0] row_id,
    input  logic [31:0] row_val1,
    input  logic [31:0] row_val2,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] out_id,
    output logic [31:0] out_val1,
    output logic [31:0] out_val2,
    output logic        last
);

    logic [1:0] key_column_reg;
    dp_cmd_t    cmd;
    dp_status_t stat;

    assign pready = 1'b1;
    assign prdata = (paddr == KEY_ADDR) ? {30'd0, key_column_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_column_reg <= KEY_ID;
        end
        else if (psel && penable && pwrite && pready && (paddr == KEY_ADDR))
        begin
            key_column_reg <= pwdata[1:0];
        end
    end

    nlej_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .stat     (stat),
        .cmd      (cmd)
    );

    nlej_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_column (key_column_reg),
        .row_id     (row_id),
        .row_val1   (row_val1),
        .row_val2   (row_val2),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .out_id     (out_id),
        .out_val1   (out_val1),
        .out_val2   (out_val2),
        .last       (last)
    );

endmodule

### test/tb_nested_loop_equi_join.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nested_loop_equi_join
// Self-checking bench for the equi-join engine. Loads, probes, clears and
// ignored words are driven over the valid/stall input channel. A scoreboard
// keeps a shadow copy of the row table and the key register. It predicts
// every result word and compares each one against the output channel, field
// by field. The key column is set through the APB port between phases, and
// each write is read back. The phases vary sender idling and receiver
// stalling. They include a long output hold that backs up the input side,
// and a run that fills the table past capacity.
// ----------------------------------------------------------------------------
module tb_nested_loop_equi_join;
    import nlej_pkg::*;

    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          SETTLE      = 100;
    localparam logic [1:0]  KEY_NONE    = 2'd3;   // unused key: probes never match
    localparam logic [1:0]  FUNC_NOP    = 2'd3;   // unused func: ignored by the block

    typedef struct packed {
        logic [2:0] status;
        word_t      id;
        word_t      val1;
        word_t      val2;
        logic       last;
    } result_t;

    class join_scoreboard;
        col_t          tbl_id[TABLE_ROWS];
        col_t          tbl_val1[TABLE_ROWS];
        col_t          tbl_val2[TABLE_ROWS];
        int unsigned   rows;
        logic [1:0]    key_col;
        result_t       pending_results[$];
        int unsigned   mismatches;

        function new();
            rows = 0;
            key_col = KEY_ID;
            mismatches = 0;
        endfunction

        function void set_key(logic [1:0] k);
            key_col = k;
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction

        function void mismatch(string what, logic [31:0] exp, logic [31:0] act);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, exp, act);
        endfunction

        function void push_marker(status_t st);
            pending_results.push_back(result_t'{st, '0, '0, '0, 1'b1});
        endfunction

        // Predict the result words caused by one accepted input word.
        function void predict_word(logic [1:0] f, row_t r);
            bit hit;
            int unsigned n;
            n = 0;
            case (f)
                FUNC_LOAD:
                begin
                    if (rows >= TABLE_ROWS)
                        push_marker(ST_FULL);
                    else
                    begin
                        tbl_id[rows] = r.id;
                        tbl_val1[rows] = r.val1;
                        tbl_val2[rows] = r.val2;
                        rows++;
                        push_marker(ST_STORED);
                    end
                end
                FUNC_CLEAR:
                begin
                    rows = 0;
                    push_marker(ST_CLEARED);
                end
                FUNC_PROBE:
                begin
                    for (int i = 0; i < rows; i++)
                    begin
                        case (key_col)
                            KEY_ID:   hit = (tbl_id[i] == r.id);
                            KEY_VAL1: hit = (tbl_val1[i] == r.val1);
                            KEY_VAL2: hit = (tbl_val2[i] == r.val2);
                            default:  hit = 1'b0;
                        endcase
                        if (hit)
                        begin
                            pending_results.push_back(
                                result_t'{ST_MATCH, r.id, r.val1, r.val2, 1'b0});
                            n++;
                        end
                    end
                    if (n == 0)
                        push_marker(ST_NOMATCH);
                    else
                        pending_results[pending_results.size() - 1].last = 1'b1;
                end
                default: ;
            endcase
        endfunction

        function void check_result(result_t got);
            result_t exp;
            if (pending_results.size() == 0)
            begin
                mismatch("unexpected word, status", 32'hx, 32'(got.status));
                return;
            end
            exp = pending_results.pop_front();
            if (got.status !== exp.status) mismatch("status", 32'(exp.status), 32'(got.status));
            if (got.id !== exp.id)         mismatch("out_id", exp.id, got.id);
            if (got.val1 !== exp.val1)     mismatch("out_val1", exp.val1, got.val1);
            if (got.val2 !== exp.val2)     mismatch("out_val2", exp.val2, got.val2);
            if (got.last !== exp.last)     mismatch("last", 32'(exp.last), 32'(got.last));
        endfunction
    endclass

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [1:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  func     = '0;
    logic [31:0] row_id   = '0;
    logic [31:0] row_val1 = '0;
    logic [31:0] row_val2 = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [31:0] out_id;
    logic [31:0] out_val1;
    logic [31:0] out_val2;
    logic        last;

    join_scoreboard sb;
    int unsigned    words_sent = 0;
    int unsigned    tx_pct = 0;
    int unsigned    rx_pct = 0;
    int unsigned    hold_req = 0;
    int unsigned    hold_seen = 0;
    int unsigned    hold_left = 0;
    int unsigned    cycles = 0;

    nested_loop_equi_join dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .row_id   (row_id),
        .row_val1 (row_val1),
        .row_val2 (row_val2),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status   (status),
        .out_id   (out_id),
        .out_val1 (out_val1),
        .out_val2 (out_val2),
        .last     (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("nested_loop_equi_join regression: fail");
        $finish;
    end

    // output side: random stall, plus a long hold whenever one is requested
    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < rx_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(result_t'{status, out_id, out_val1, out_val2, last});
    end

    function automatic word_t pick_value();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 15)
            return '0;
        else if (roll < 30)
            return '1;
        return $urandom;
    endfunction

    function automatic row_t make_row(input word_t pool[4], input int unsigned npool);
        row_t r;
        r.id   = ($urandom_range(99) < 60) ? pool[$urandom_range(npool - 1)] : $urandom;
        r.val1 = ($urandom_range(99) < 60) ? pool[$urandom_range(npool - 1)] : $urandom;
        r.val2 = ($urandom_range(99) < 60) ? pool[$urandom_range(npool - 1)] : $urandom;
        return r;
    endfunction

    function automatic row_t noise_row();
        return row_t'{col_t'($urandom), col_t'($urandom), col_t'($urandom)};
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input logic [1:0] f, input row_t r);
        while ($urandom_range(99) < tx_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        row_id   <= r.id;
        row_val1 <= r.val1;
        row_val2 <= r.val2;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.predict_word(f, r);
        if (f != FUNC_NOP)
            words_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.outstanding() != 0)
            @(negedge clk);
    endtask

    // write the key register, then read it back
    task automatic set_key_column(input logic [1:0] k);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= KEY_ADDR;
        pwdata  <= 32'(k);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_key(k);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== 32'(k))
            sb.mismatch("key_column readback", 32'(k), prdata);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic next_phase(input logic [1:0] k, input int unsigned tx, input int unsigned rx);
        drain();
        // an ignored word may still be in flight after the last result
        repeat (SETTLE) @(negedge clk);
        tx_pct = tx;
        rx_pct <= rx;
        set_key_column(k);
    endtask

    // clear (mostly), a batch of loads, then probes mixed with stray words
    task automatic run_batch(input bit fill_table);
        word_t       pool[4];
        row_t        loaded[$];
        row_t        r;
        int unsigned n_load;
        int unsigned n_probe;
        int unsigned roll;
        for (int i = 0; i < 4; i++)
            pool[i] = pick_value();
        if (fill_table || $urandom_range(99) < 70)
            send_word(FUNC_CLEAR, noise_row());
        n_load = fill_table ? TABLE_ROWS + 2 : $urandom_range(1, 8);
        repeat (n_load)
        begin
            r = make_row(pool, fill_table ? 2 : 4);
            loaded.push_back(r);
            send_word(FUNC_LOAD, r);
        end
        n_probe = fill_table ? 6 : $urandom_range(1, 6);
        repeat (n_probe)
        begin
            roll = $urandom_range(99);
            if (roll < 8)
            begin
                r = make_row(pool, 4);
                loaded.push_back(r);
                send_word(FUNC_LOAD, r);
            end
            else if (roll < 13)
                send_word(FUNC_NOP, noise_row());
            else if (roll < 16)
                send_word(FUNC_CLEAR, noise_row());
            else if ($urandom_range(99) < 50)
                send_word(FUNC_PROBE, loaded[$urandom_range(loaded.size() - 1)]);
            else
                send_word(FUNC_PROBE, make_row(pool, 4));
        end
        if ($urandom_range(99) < 15)
            drain();
    endtask

    task automatic run_until(input int unsigned target);
        while (words_sent < target)
            run_batch(1'b0);
    endtask

    initial
    begin
        sb = new();
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty table, extremes, duplicates, clear
        set_key_column(KEY_ID);
        send_word(FUNC_PROBE, row_t'{32'h0, 32'h0, 32'h0});
        send_word(FUNC_NOP,   row_t'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        send_word(FUNC_LOAD,  row_t'{32'h0, 32'h0, 32'h0});
        send_word(FUNC_LOAD,  row_t'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        send_word(FUNC_LOAD,  row_t'{32'd5, 32'hA5A5_A5A5, 32'h5A5A_5A5A});
        send_word(FUNC_LOAD,  row_t'{32'd5, 32'd1, 32'd2});
        send_word(FUNC_LOAD,  row_t'{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF});
        send_word(FUNC_PROBE, row_t'{32'd5, 32'h1234_5678, 32'h9ABC_DEF0});
        send_word(FUNC_PROBE, row_t'{32'hFFFF_FFFF, 32'h0, 32'h0});
        send_word(FUNC_PROBE, row_t'{32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        send_word(FUNC_PROBE, row_t'{32'd7, 32'd5, 32'd5});
        send_word(FUNC_CLEAR, row_t'{32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF});
        send_word(FUNC_PROBE, row_t'{32'd5, 32'd1, 32'd2});
        send_word(FUNC_LOAD,  row_t'{32'd9, 32'd3, 32'd4});
        send_word(FUNC_PROBE, row_t'{32'd9, 32'h0, 32'h0});

        // long output hold while the table fills up and overflows
        hold_req <= hold_req + 1;
        run_batch(1'b1);
        run_until(100);

        next_phase(KEY_VAL1, 86, 0);
        run_until(150);

        next_phase(KEY_VAL2, 0, 86);
        run_until(200);

        next_phase(KEY_NONE, 15, 15);
        run_until(225);

        next_phase(KEY_ID, 15, 15);
        run_until(275);

        drain();
        repeat (SETTLE) @(negedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("nested_loop_equi_join regression: pass");
        else
            $display("nested_loop_equi_join regression: fail");
        $finish;
    end

endmodule

### sim.f
design/nlej_pkg.sv
design/nlej_ctrl.sv
design/nlej_dp.sv
design/nested_loop_equi_join.sv
test/tb_nested_loop_equi_join.sv
